// File: sv/bounded_unique_id_list_top_macros.svh
// Assertion macros for the bounded unique-ID list checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef BOUNDED_UNIQUE_ID_LIST_TOP_MACROS_SVH
`define BOUNDED_UNIQUE_ID_LIST_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define BUL_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge out of reset.
`define BUL_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// File: sv/bul_pkg.sv
// Shared types and constants for the bounded unique-ID list.
// No dependencies; imported by every RTL module of the block.
package bul_pkg;

    localparam int ID_W   = 32;   // stored ID width
    localparam int CNT_W  = 5;    // entry count and capacity width
    localparam int IDX_W  = 8;    // slot index, enough for 256 slots
    localparam int SLOT_W = 9;    // slot number incl. the value 256
    localparam int IN_W   = 40;   // mode + ID, padded to bytes
    localparam int OUT_W  = 8;    // ok + count, padded to bytes
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] CAP_RESET = 5'd16;
    localparam logic             REG_CAPACITY = 1'b0;   // word index of capacity_limit

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_APPLY = 1'b1
    } st_t;

    // Broadcast to every cell
    typedef struct packed {
        logic              add;         // write key into slot at count
        logic              remove;      // slots at/above remove_idx take neighbour
        logic [CNT_W-1:0]  count;       // entries currently held
        logic [IDX_W-1:0]  remove_idx;  // slot of the matched entry
    } cell_ctl_t;

endpackage

// File: sv/bul_cell.sv
// One slot of the ID chain: holds an ID, compares it with the key,
// loads the key on append or its upper neighbour's ID on remove. Uses bul_pkg.
module bul_cell #(
    parameter int INDEX = 0
) (
    input  logic                      clk,
    input  logic [bul_pkg::ID_W-1:0]  key,
    input  bul_pkg::cell_ctl_t        ctl,
    input  logic [bul_pkg::ID_W-1:0]  next_id,
    output logic [bul_pkg::ID_W-1:0]  id,
    output logic                      hit
);
    import bul_pkg::*;

    localparam logic [SLOT_W-1:0] SLOT = SLOT_W'(INDEX);

    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] id_next;
    logic            live;

    assign live = SLOT < {{(SLOT_W-CNT_W){1'b0}}, ctl.count};
    assign hit  = live && (id_reg == key);
    assign id   = id_reg;

    always_comb
    begin
        id_next = id_reg;
        if (ctl.add && (SLOT == {{(SLOT_W-CNT_W){1'b0}}, ctl.count}))
        begin
            id_next = key;
        end
        else if (ctl.remove && (SLOT >= {1'b0, ctl.remove_idx}))
        begin
            id_next = next_id;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

endmodule

// File: sv/bul_hit_enc.sv
// Turns the cells' hit vector into a found flag and a slot index.
// At most one cell hits, since held IDs are distinct. Uses bul_pkg.
module bul_hit_enc #(
    parameter int DEPTH = 16
) (
    input  logic [DEPTH-1:0]          match,
    output logic                      any,
    output logic [bul_pkg::IDX_W-1:0] idx
);
    import bul_pkg::*;

    assign any = |match;

    // OR of the indices of hitting slots; single hit gives its index
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (match[i])
            begin
                idx = idx | IDX_W'(i);
            end
        end
    end

endmodule

// File: sv/bounded_unique_id_list_top.sv
// Bounded unique-ID list, top level: FSM, count, capacity register and the cell chain.
// Depends on bul_pkg, bul_cell and bul_hit_enc.
//
// Use:
//   Input stream (s_*): one transfer per operation, s_tdata = {pad, item_id, mode}.
//   mode: add, remove, clear all, query membership.
//   Output stream (m_*): one transfer per operation, m_tdata = {pad, entry_count, ok}.
//   APB port: capacity_limit at address 0 (reads back), reset value 16.
// Timing:
//   In the accept cycle every cell compares the incoming ID with its own entry at once
//   and the hit encoder's matching slot is registered; once the output register is free,
//   the chain applies the change (append at the tail, or every slot from the hit upward
//   takes its upper neighbour's ID) and the result is registered onto m_tvalid/m_tdata.
//   A new item is accepted only after the previous one has been applied.
// Reset: count cleared to zero, output empty, capacity back to 16. ID slots are not
//   reset; slots at or above the count are never read.
// Stall: the result sits in the output register; the next item is accepted meanwhile,
//   and its apply step waits until the output register is free.
module bounded_unique_id_list_top #(
    parameter int DEPTH = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // input stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bul_pkg::IN_W-1:0]    s_tdata,   // [1:0] mode, [33:2] item_id, [39:34] 0
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bul_pkg::OUT_W-1:0]   m_tdata,   // [0] ok, [5:1] entry_count, [7:6] 0
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bul_pkg::ADDR_W-1:0]  paddr,
    input  logic [bul_pkg::DATA_W-1:0]  pwdata,
    output logic [bul_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import bul_pkg::*;

    st_t               state_reg, state_next;
    mode_t             mode_reg;
    logic [ID_W-1:0]   key_reg;
    logic              hit_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  cap_reg;
    logic              m_valid_reg, m_valid_next;
    logic              ok_reg, ok_next;
    logic [CNT_W-1:0]  cnt_out_reg;

    logic              in_xfer;
    logic              out_free;
    logic              apply_go;
    logic [ID_W-1:0]   in_id;
    logic [ID_W-1:0]   key;
    logic [DEPTH-1:0]  match;
    logic              any_hit;
    logic [IDX_W-1:0]  hit_idx;
    logic [SLOT_W-1:0] cap_ext;
    logic [SLOT_W-1:0] eff_cap;
    logic              has_room;
    cell_ctl_t         ctl;

    logic [ID_W-1:0]   cell_id [DEPTH];

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {{(DATA_W-CNT_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CNT_W-1:0];
        end
    end

    // A capacity above the slot count acts as the slot count
    assign cap_ext  = {{(SLOT_W-CNT_W){1'b0}}, cap_reg};
    assign eff_cap  = (cap_ext > SLOT_W'(DEPTH)) ? SLOT_W'(DEPTH) : cap_ext;
    assign has_room = {{(SLOT_W-CNT_W){1'b0}}, count_reg} < eff_cap;

    // ---------------- handshakes ----------------
    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign apply_go = (state_reg == ST_APPLY) && out_free;

    assign in_id = s_tdata[ID_W+1:2];
    // cells compare the incoming ID while idle, write the held key while applying
    assign key   = (state_reg == ST_IDLE) ? in_id : key_reg;

    // ---------------- cell chain ----------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0] upper_id;
        if (i == DEPTH - 1)
        begin : g_last
            assign upper_id = cell_id[i];
        end
        else
        begin : g_mid
            assign upper_id = cell_id[i+1];
        end

        bul_cell #(
            .INDEX (i)
        ) u_cell (
            .clk     (clk),
            .key     (key),
            .ctl     (ctl),
            .next_id (upper_id),
            .id      (cell_id[i]),
            .hit     (match[i])
        );
    end

    bul_hit_enc #(
        .DEPTH (DEPTH)
    ) u_enc (
        .match (match),
        .any   (any_hit),
        .idx   (hit_idx)
    );

    // ---------------- control ----------------
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ok_next        = ok_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        ctl.add        = 1'b0;
        ctl.remove     = 1'b0;
        ctl.count      = count_reg;
        ctl.remove_idx = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                if (out_free)
                begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                    unique case (mode_reg)
                        MODE_ADD:
                        begin
                            ok_next = !hit_reg && has_room;
                            if (!hit_reg && has_room)
                            begin
                                ctl.add    = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_REMOVE:
                        begin
                            ok_next = hit_reg;
                            if (hit_reg)
                            begin
                                ctl.remove = 1'b1;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        MODE_CLEAR:
                        begin
                            ok_next    = 1'b1;
                            count_next = '0;
                        end
                        MODE_QUERY:
                        begin
                            ok_next = hit_reg;
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            mode_reg <= mode_t'(s_tdata[1:0]);
            key_reg  <= in_id;
            hit_reg  <= any_hit;
            idx_reg  <= hit_idx;
        end
        if (apply_go)
        begin
            ok_reg      <= ok_next;
            cnt_out_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W-CNT_W-1){1'b0}}, cnt_out_reg, ok_reg};

endmodule

// File: sv/bul_checker.sv
// Port-level checker for the bounded unique-ID list, bound to the top level.
// Depends on bul_pkg and bounded_unique_id_list_top_macros.svh.
`include "bounded_unique_id_list_top_macros.svh"

module bul_checker #(
    parameter int DEPTH = 16
) (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [bul_pkg::OUT_W-1:0]   m_tdata
);
    import bul_pkg::*;

    localparam int          CNT_LIM  = (DEPTH < 31) ? DEPTH : 31;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(CNT_LIM);

    // count can never pass the slot count
    `BUL_ASSERT_NOW(a_count_bound, m_tvalid, m_tdata[5:1] <= CNT_MAX, "entry_count above depth")

    // one item in flight: the input closes right after a transfer
    `BUL_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken early")

    // a fresh result only follows an item that was being worked on
    `BUL_ASSERT_NOW(a_result_cause, $rose(m_tvalid), !$past(s_tready), "result without an item")

    // stalled result holds
    `BUL_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result moved")

endmodule

bind bounded_unique_id_list_top bul_checker #(
    .DEPTH (DEPTH)
) u_bul_checker (.*);
